>>> src/ira_pkg.sv
// Shared types, codes and character helpers for the integer to ASCII converter.
`timescale 1ns / 1ps

package ira_pkg;

   // Default width of the value to print
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Number base codes as held in the base register
   typedef enum logic [1:0] {
      BASE_BIN = 2'd0,
      BASE_OCT = 2'd1,
      BASE_DEC = 2'd2,
      BASE_HEX = 2'd3
   } base_type;

   // Base register value after reset
   localparam base_type BASE_RESET = BASE_DEC;

   // Sequencer states, one-hot
   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_DABBLE  = 7'b0000010,
      ST_SIGN    = 7'b0000100,
      ST_PREFIX0 = 7'b0001000,
      ST_PREFIXX = 7'b0010000,
      ST_SKIP    = 7'b0100000,
      ST_DIGIT   = 7'b1000000
   } state_type;

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_A_LOWER = 8'h61;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_X_LOWER = 8'h78;
   localparam logic [3:0] DIGIT_TEN    = 4'd10;

   // Map a digit value 0..15 to its lower-case ASCII character
   function automatic logic [7:0] digit_char(input logic [3:0] digit);
      logic [7:0] code;
      if (digit < DIGIT_TEN) begin
         code = CHAR_ZERO + {4'b0000, digit};
      end else begin
         code = CHAR_A_LOWER + {4'b0000, digit - DIGIT_TEN};
      end
      return code;
   endfunction

endpackage

>>> src/ira_dabble.sv
// One double-dabble step: add-three correction on every BCD digit, then shift in one bit.
`timescale 1ns / 1ps

module ira_dabble #(
   parameter int DIGITS = 10
) (
   input  logic [4*DIGITS-1:0] bcd_in,
   input  logic                bit_in,
   output logic [4*DIGITS-1:0] bcd_out
);

   logic [4*DIGITS-1:0] adjusted;

   // Correct each digit that would overflow past nine on the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_in[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = bcd_in[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = bcd_in[4*i +: 4];
         end
      end
   end

   // Shift the next binary bit in at the bottom
   assign bcd_out = {adjusted[4*DIGITS-2:0], bit_in};

endmodule

>>> src/integer_to_radix_ascii.sv
// Top level: prints one integer per item as ASCII characters in binary, octal, decimal or hex.
`timescale 1ns / 1ps

// Takes one integer per input item and emits its characters one per output item, most
// significant first: an optional '-', then "0" for octal or "0x" for hex, then the digits
// without leading zeros, with rsp_last on the final character. The block works on one item at
// a time and holds req_stall high until the final character has been loaded into the output
// register. A decimal item first runs through the shared double-dabble step, one value bit per
// cycle; the other bases load their digits directly. Every item then passes the sign and
// prefix states as needed, skips leading-zero digit slots and prints the remaining slots.
// Output stalls hold the states that emit a character.
module integer_to_radix_ascii #(
   parameter int VALUE_WIDTH = ira_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [1:0]             csr_wr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   req_is_signed,
   input  logic                   req_as_address,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_char_code,
   output logic                   rsp_last
);

   // Digit slot counts and the width of the digit register
   localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BIN_BITS   = VALUE_WIDTH;
   localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
   localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
   localparam int DEC_BITS   = 4 * DEC_DIGITS;
   localparam int OCT_BITS   = 3 * OCT_DIGITS;
   localparam int HEX_BITS   = 4 * HEX_DIGITS;
   localparam int MAX_PH     = (OCT_BITS > HEX_BITS) ? OCT_BITS : HEX_BITS;
   localparam int WORK_W     = (DEC_BITS > MAX_PH) ? DEC_BITS : MAX_PH;
   localparam int CNT_W      = $clog2(WORK_W + 1);

   ira_pkg::state_type       state_ff, state_in;
   ira_pkg::base_type        base_ff, base_in;
   ira_pkg::base_type        sel_ff, sel_in;
   logic                     neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0]   mag_ff, mag_in;
   logic [WORK_W-1:0]        work_ff, work_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     req_accept;
   logic                     emit_ok;
   logic                     req_neg;
   logic [VALUE_WIDTH-1:0]   req_mag;
   ira_pkg::base_type        req_sel;
   logic [WORK_W-1:0]        mag_wide;
   logic [DEC_BITS-1:0]      dabble_out;
   logic [3:0]               digit;
   logic [WORK_W-1:0]        work_shifted;
   logic                     cnt_is_one;

   assign req_stall  = (state_ff != ira_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign emit_ok    = !rsp_valid_ff || !rsp_stall;
   assign cnt_is_one = (cnt_ff == CNT_W'(1));

   // Decode the incoming item: base, sign and magnitude
   assign req_sel  = req_as_address ? ira_pkg::BASE_HEX : base_ff;
   assign req_neg  = !req_as_address && req_is_signed && req_value[VALUE_WIDTH-1];
   assign req_mag  = req_neg ? (~req_value + VALUE_WIDTH'(1)) : req_value;
   assign mag_wide = {{(WORK_W - VALUE_WIDTH){1'b0}}, req_mag};

   // Shared conversion step for decimal
   ira_dabble #(
      .DIGITS (DEC_DIGITS)
   ) u_dabble (
      .bcd_in  (work_ff[WORK_W-1 -: DEC_BITS]),
      .bit_in  (mag_ff[VALUE_WIDTH-1]),
      .bcd_out (dabble_out)
   );

   // Take the top digit and advance the digit register by one digit
   always_comb begin
      case (sel_ff)
         ira_pkg::BASE_BIN: begin
            digit        = {3'b000, work_ff[WORK_W-1]};
            work_shifted = work_ff << 1;
         end
         ira_pkg::BASE_OCT: begin
            digit        = {1'b0, work_ff[WORK_W-1 -: 3]};
            work_shifted = work_ff << 3;
         end
         default: begin
            digit        = work_ff[WORK_W-1 -: 4];
            work_shifted = work_ff << 4;
         end
      endcase
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      sel_in       = sel_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      work_in      = work_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_wr_en) begin
         base_in = ira_pkg::base_type'(csr_wr_data);
      end

      unique case (state_ff)
         ira_pkg::ST_IDLE: begin
            if (req_accept) begin
               sel_in = req_sel;
               neg_in = req_neg;
               mag_in = req_mag;
               case (req_sel)
                  ira_pkg::BASE_BIN: begin
                     work_in = mag_wide << (WORK_W - BIN_BITS);
                     cnt_in  = CNT_W'(BIN_BITS);
                  end
                  ira_pkg::BASE_OCT: begin
                     work_in = mag_wide << (WORK_W - OCT_BITS);
                     cnt_in  = CNT_W'(OCT_DIGITS);
                  end
                  ira_pkg::BASE_HEX: begin
                     work_in = mag_wide << (WORK_W - HEX_BITS);
                     cnt_in  = CNT_W'(HEX_DIGITS);
                  end
                  default: begin
                     work_in = '0;
                     cnt_in  = CNT_W'(VALUE_WIDTH);
                  end
               endcase
               if (req_sel == ira_pkg::BASE_DEC) begin
                  state_in = ira_pkg::ST_DABBLE;
               end else if (req_neg) begin
                  state_in = ira_pkg::ST_SIGN;
               end else if (req_sel == ira_pkg::BASE_BIN) begin
                  state_in = ira_pkg::ST_SKIP;
               end else begin
                  state_in = ira_pkg::ST_PREFIX0;
               end
            end
         end
         ira_pkg::ST_DABBLE: begin
            // One value bit per cycle into the BCD digits
            work_in = WORK_W'({dabble_out, {(WORK_W - DEC_BITS){1'b0}}});
            mag_in  = mag_ff << 1;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_is_one) begin
               cnt_in   = CNT_W'(DEC_DIGITS);
               state_in = neg_ff ? ira_pkg::ST_SIGN : ira_pkg::ST_SKIP;
            end
         end
         ira_pkg::ST_SIGN: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ira_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
               if (sel_ff == ira_pkg::BASE_OCT || sel_ff == ira_pkg::BASE_HEX) begin
                  state_in = ira_pkg::ST_PREFIX0;
               end else begin
                  state_in = ira_pkg::ST_SKIP;
               end
            end
         end
         ira_pkg::ST_PREFIX0: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ira_pkg::CHAR_ZERO;
               rsp_last_in  = 1'b0;
               state_in     = (sel_ff == ira_pkg::BASE_HEX) ? ira_pkg::ST_PREFIXX
                                                            : ira_pkg::ST_SKIP;
            end
         end
         ira_pkg::ST_PREFIXX: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ira_pkg::CHAR_X_LOWER;
               rsp_last_in  = 1'b0;
               state_in     = ira_pkg::ST_SKIP;
            end
         end
         ira_pkg::ST_SKIP: begin
            // Drop leading zeros, keeping at least one digit
            if (digit == 4'd0 && !cnt_is_one) begin
               work_in = work_shifted;
               cnt_in  = cnt_ff - CNT_W'(1);
            end else begin
               state_in = ira_pkg::ST_DIGIT;
            end
         end
         ira_pkg::ST_DIGIT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ira_pkg::digit_char(digit);
               rsp_last_in  = cnt_is_one;
               work_in      = work_shifted;
               cnt_in       = cnt_ff - CNT_W'(1);
               if (cnt_is_one) begin
                  state_in = ira_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ira_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ira_pkg::ST_IDLE;
         base_ff      <= ira_pkg::BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      sel_ff      <= sel_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      work_ff     <= work_in;
      cnt_ff      <= cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

>>> dv/integer_to_radix_ascii_test.sv
// Self-checking testbench for the integer to radix ASCII converter.
`timescale 1ns / 1ps

module integer_to_radix_ascii_test;

   localparam int VALUE_BITS = 32;

   // One expected character of a printed number
   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } ascii_char_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [1:0]            csr_wr_data = 2'd0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  req_is_signed = 1'b0;
   logic                  req_as_address = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_char_code;
   logic                  rsp_last;

   // Predictor state and scoreboard
   ira_pkg::base_type base_setting = ira_pkg::BASE_RESET;
   ascii_char_type    pending_chars[$];
   int unsigned       req_idle_pct = 0;
   int unsigned       rsp_idle_pct = 0;
   int unsigned       error_count = 0;
   int unsigned       numbers_sent = 0;
   int unsigned       chars_checked = 0;
   int unsigned       base_writes = 0;

   integer_to_radix_ascii #(
      .VALUE_WIDTH(VALUE_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_is_signed (req_is_signed),
      .req_as_address(req_as_address),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard limit on run time
   initial begin
      #10_000_000;
      $display("timeout with %0d characters still expected", pending_chars.size());
      $display("simulation failed");
      $finish;
   end

   function automatic logic [31:0] radix_of(input ira_pkg::base_type sel);
      logic [31:0] radix;
      case (sel)
         ira_pkg::BASE_BIN: radix = 32'd2;
         ira_pkg::BASE_OCT: radix = 32'd8;
         ira_pkg::BASE_DEC: radix = 32'd10;
         default:           radix = 32'd16;
      endcase
      return radix;
   endfunction

   // Work out the characters of one number and queue them
   function automatic void predict_text(input logic [VALUE_BITS-1:0] value,
                                        input logic sgn, input logic addr);
      ira_pkg::base_type     sel;
      logic [VALUE_BITS-1:0] magnitude;
      logic [31:0]           radix;
      logic [7:0]            digit;
      logic [7:0]            digits[$];
      ascii_char_type        chars[$];
      sel = addr ? ira_pkg::BASE_HEX : base_setting;
      radix = radix_of(sel);
      magnitude = value;
      if (!addr && sgn && value[VALUE_BITS-1]) begin
         chars.push_back('{char_code: ira_pkg::CHAR_MINUS, last: 1'b0});
         magnitude = -value;
      end
      if (sel == ira_pkg::BASE_OCT || sel == ira_pkg::BASE_HEX) begin
         chars.push_back('{char_code: ira_pkg::CHAR_ZERO, last: 1'b0});
      end
      if (sel == ira_pkg::BASE_HEX) begin
         chars.push_back('{char_code: ira_pkg::CHAR_X_LOWER, last: 1'b0});
      end
      // Peel digits least significant first, then emit in print order
      do begin
         digits.push_front(8'(magnitude % radix));
         magnitude = magnitude / radix;
      end while (magnitude != 0);
      foreach (digits[i]) begin
         digit = digits[i];
         chars.push_back('{char_code: (digit < 8'd10) ? ira_pkg::CHAR_ZERO + digit
                                                      : ira_pkg::CHAR_A_LOWER + digit - 8'd10,
                           last: 1'b0});
      end
      chars[chars.size()-1].last = 1'b1;
      foreach (chars[i]) pending_chars.push_back(chars[i]);
   endfunction

   function automatic void note_failure(input string what);
      error_count++;
      if (error_count <= 10) $display("mismatch: %s", what);
   endfunction

   // Receiver stall pattern
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   // Compare each accepted character with the oldest expectation
   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            note_failure($sformatf("unexpected char 0x%02h last %0b",
                                   rsp_char_code, rsp_last));
         end else begin
            want = pending_chars.pop_front();
            chars_checked++;
            if (rsp_char_code !== want.char_code || rsp_last !== want.last) begin
               note_failure($sformatf("char expected 0x%02h last %0b, got 0x%02h last %0b",
                                      want.char_code, want.last, rsp_char_code, rsp_last));
            end
         end
      end
   end

   // Send one number; enter and leave at a falling edge
   task automatic send_number(input logic [VALUE_BITS-1:0] value,
                              input logic sgn, input logic addr);
      while ($urandom_range(0, 99) < req_idle_pct) @(negedge clock);
      req_value = value;
      req_is_signed = sgn;
      req_as_address = addr;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      predict_text(value, sgn, addr);
      numbers_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Hold off until every expected character has come out
   task automatic wait_drained();
      while (pending_chars.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_base(input ira_pkg::base_type sel);
      wait_drained();
      csr_wr_en = 1'b1;
      csr_wr_data = sel;
      @(negedge clock);
      csr_wr_en = 1'b0;
      base_setting = sel;
      base_writes++;
   endtask

   // Pick a value that stresses the current base
   function automatic logic [VALUE_BITS-1:0] pick_value();
      logic [63:0] power;
      logic [31:0] radix;
      int          steps;
      logic [VALUE_BITS-1:0] value;
      radix = radix_of(base_setting);
      case ($urandom_range(0, 5))
         0: value = $urandom;
         1: value = $urandom_range(0, radix * radix);
         2: begin
            power = 64'd1;
            steps = $urandom_range(0, 31);
            while (steps > 0 && power * radix <= 64'hFFFF_FFFF) begin
               power = power * radix;
               steps--;
            end
            value = VALUE_BITS'(power) + $urandom_range(0, 2) - 1;
         end
         3: begin
            case ($urandom_range(0, 3))
               0: value = 32'h8000_0000;
               1: value = 32'h7FFF_FFFF;
               2: value = 32'hFFFF_FFFF;
               default: value = 32'h0000_0000;
            endcase
         end
         4: value = $urandom >> $urandom_range(0, 31);
         default: value = -($urandom_range(0, 300));
      endcase
      return value;
   endfunction

   // Numbers printed in decimal straight out of reset
   task automatic test_reset_base();
      send_number(32'd0, 1'b0, 1'b0);
      send_number(32'd9, 1'b0, 1'b0);
      send_number(32'd10, 1'b0, 1'b0);
      send_number(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_number(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_number(32'h8000_0000, 1'b1, 1'b0);
      send_number(32'h7FFF_FFFF, 1'b1, 1'b0);
   endtask

   // Zero, all ones, most negative and the radix itself in every base
   task automatic test_each_base();
      ira_pkg::base_type order[4] = '{ira_pkg::BASE_BIN, ira_pkg::BASE_OCT,
                                      ira_pkg::BASE_HEX, ira_pkg::BASE_DEC};
      foreach (order[i]) begin
         set_base(order[i]);
         send_number(32'd0, 1'b1, 1'b0);
         send_number(32'hFFFF_FFFF, 1'b0, 1'b0);
         send_number(32'h8000_0000, 1'b1, 1'b0);
         send_number(radix_of(order[i]), 1'b1, 1'b0);
      end
   endtask

   // Address form overrides base and sign
   task automatic test_address_flag();
      set_base(ira_pkg::BASE_BIN);
      send_number(32'h8000_0000, 1'b1, 1'b1);
      send_number(32'd0, 1'b0, 1'b1);
   endtask

   // Random numbers with base changes between bursts
   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                      input int count);
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) set_base(ira_pkg::base_type'($urandom_range(0, 3)));
         send_number(pick_value(), 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      req_idle_pct = 20;
      rsp_idle_pct = 20;
      test_reset_base();
      test_each_base();
      test_address_flag();
      test_random_traffic(34, 73, 129);
      test_random_traffic(73, 34, 128);
      test_random_traffic(0, 0, 128);

      // Drain, then watch for stray characters
      while (pending_chars.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);

      $display("printed %0d numbers as %0d checked characters across %0d base writes,",
               numbers_sent, chars_checked, base_writes);
      $display("signed, unsigned and address forms, with and without stalls on both sides");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", error_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/ira_pkg.sv
src/ira_dabble.sv
src/integer_to_radix_ascii.sv
dv/integer_to_radix_ascii_test.sv
